[hw/rtl/residual_gap_interpolator_defines.svh]
// Assertion macros for the residual gap interpolator.
// Used by the RTL files that carry concurrent checks; depends on nothing.
`ifndef RESIDUAL_GAP_INTERPOLATOR_DEFINES_SVH
`define RESIDUAL_GAP_INTERPOLATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define RGI_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rgi check failed");

// Next-cycle implication, disabled while reset is low.
`define RGI_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rgi check failed");

`endif

[hw/rtl/rgi_pkg.sv]
// Shared types and constants of the residual gap interpolator.
// Used by rgi_ctrl, rgi_dpath and the top level; depends on nothing.
package rgi_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned GapW     = 6;
  localparam int unsigned CntW     = GapW + 1;
  localparam int unsigned DivSteps = DataW;
  localparam int unsigned StepW    = $clog2(DivSteps);

  localparam logic [GapW-1:0] MAX_GAP = GapW'(63);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SETUP = 6'b000010,
    ST_DIV   = 6'b000100,
    ST_FIX   = 6'b001000,
    ST_INIT  = 6'b010000,
    ST_EMIT  = 6'b100000
  } rgi_state_t;

  typedef struct packed {
    logic accept;
    logic setup;
    logic div_step;
    logic fix;
    logic init;
    logic emit;
  } rgi_cmd_t;

  typedef struct packed {
    logic absorb;
    logic need_div;
    logic div_done;
    logic out_free;
    logic last_emit;
  } rgi_sts_t;

endpackage

[hw/rtl/rgi_ctrl.sv]
// Controller of the residual gap interpolator: sequences accept, divide,
// blend setup and result emission. Depends on rgi_pkg.
module rgi_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rgi_pkg::rgi_sts_t sts,
  output rgi_pkg::rgi_cmd_t cmd
);
  import rgi_pkg::*;

  rgi_state_t state_r, state_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.accept   = in_valid && (state_r == ST_IDLE);
    cmd.setup    = (state_r == ST_SETUP);
    cmd.div_step = (state_r == ST_DIV);
    cmd.fix      = (state_r == ST_FIX);
    cmd.init     = (state_r == ST_INIT);
    cmd.emit     = (state_r == ST_EMIT) && sts.out_free;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.accept && !sts.absorb) begin
          state_nxt = sts.need_div ? ST_SETUP : ST_EMIT;
        end
      end
      ST_SETUP: state_nxt = ST_DIV;
      ST_DIV: begin
        if (sts.div_done) begin
          state_nxt = ST_FIX;
        end
      end
      ST_FIX:  state_nxt = ST_INIT;
      ST_INIT: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (cmd.emit && sts.last_emit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[hw/rtl/rgi_dpath.sv]
// Datapath of the residual gap interpolator: residual, log state, serial
// divider, blend accumulator and output register. Depends on rgi_pkg.
`include "residual_gap_interpolator_defines.svh"

module rgi_dpath (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic signed [rgi_pkg::DataW-1:0]       in_log_value,
  input  logic signed [rgi_pkg::DataW-1:0]       in_background_value,
  input  logic                                   in_is_missing,
  input  logic                                   in_last_sample,
  input  rgi_pkg::rgi_cmd_t                      cmd,
  output rgi_pkg::rgi_sts_t                      sts,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [rgi_pkg::DataW-1:0]       out_residual,
  output logic                                   out_was_filled,
  output logic                                   out_gap_overflow,
  output logic                                   out_run_end
);
  import rgi_pkg::*;

  // log state
  logic [DataW-1:0] prev_r;
  logic             seen_r;
  logic [GapW-1:0]  gap_r;

  // captured item
  logic [DataW-1:0] res_r;
  logic             miss_r;
  logic             last_r;
  logic [CntW-1:0]  den_r;
  logic [CntW-1:0]  idx_r;

  // serial divider and blend accumulator
  logic [DataW-1:0] dvd_r;
  logic [CntW-1:0]  rem_r;
  logic             neg_r;
  logic [StepW-1:0] step_r;
  logic [DataW:0]   qd_r;
  logic [CntW-1:0]  rd_r;
  logic [DataW:0]   acc_q_r;
  logic [CntW-1:0]  acc_r_r;

  // output register
  logic             out_valid_r;
  logic [DataW-1:0] out_residual_r;
  logic             out_filled_r;
  logic             out_ovf_r;
  logic             out_end_r;

  logic [DataW:0]   diff_in;
  logic [DataW-1:0] res_in;
  logic [CntW-1:0]  den_in;
  logic [DataW:0]   d_set;
  logic [DataW:0]   mag_set;
  logic [CntW:0]    rem_sh;
  logic [CntW:0]    rem_sub;
  logic             rem_ge;
  logic             rem_zero;
  logic [DataW:0]   mag_ext;
  logic [DataW:0]   qd_fix;
  logic [CntW-1:0]  rd_fix;
  logic [CntW:0]    sum_rem;
  logic [CntW:0]    sum_sub;
  logic             carry;
  logic [CntW-1:0]  half;
  logic [CntW-1:0]  thr;
  logic             round_up;
  logic [DataW:0]   blend_full;
  logic [DataW-1:0] emit_val;
  logic             emit_filled;
  logic             emit_ovf;

  // residual with saturation
  assign diff_in = {in_log_value[DataW-1], in_log_value}
                 - {in_background_value[DataW-1], in_background_value};

  always_comb begin
    if (diff_in[DataW] != diff_in[DataW-1]) begin
      res_in = diff_in[DataW] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
    end else begin
      res_in = diff_in[DataW-1:0];
    end
  end

  assign den_in = {1'b0, gap_r} + CntW'(1);

  assign sts.absorb    = in_is_missing && !in_last_sample && (gap_r < MAX_GAP);
  assign sts.need_div  = !in_is_missing && (gap_r != '0) && seen_r;
  assign sts.div_done  = (step_r == StepW'(DivSteps - 1));
  assign sts.out_free  = !out_valid_r || !out_stall;
  assign sts.last_emit = (idx_r == CntW'(1));

  // magnitude of new minus previous residual
  assign d_set   = {res_r[DataW-1], res_r} - {prev_r[DataW-1], prev_r};
  assign mag_set = d_set[DataW] ? (~d_set + (DataW+1)'(1)) : d_set;

  // one restoring step: one quotient bit per cycle
  assign rem_sh  = {rem_r, dvd_r[DataW-1]};
  assign rem_sub = rem_sh - {1'b0, den_r};
  assign rem_ge  = (rem_sh >= {1'b0, den_r});

  // turn magnitude quotient into floor quotient and nonnegative remainder
  assign rem_zero = (rem_r == '0);
  assign mag_ext  = {1'b0, dvd_r};
  assign qd_fix   = neg_r ? (~mag_ext + {{DataW{1'b0}}, rem_zero}) : mag_ext;
  assign rd_fix   = (neg_r && !rem_zero) ? (den_r - rem_r) : rem_r;

  // advance the blend by one step of the gap
  assign sum_rem = {1'b0, acc_r_r} + {1'b0, rd_r};
  assign sum_sub = sum_rem - {1'b0, den_r};
  assign carry   = (sum_rem >= {1'b0, den_r});

  // round to nearest, ties away from zero
  assign half       = den_r >> 1;
  assign thr        = den_r - half;
  assign round_up   = acc_q_r[DataW] ? (acc_r_r > half) : (acc_r_r >= thr);
  assign blend_full = acc_q_r + {{DataW{1'b0}}, round_up};

  always_comb begin
    if (miss_r) begin
      emit_val    = prev_r;
      emit_filled = 1'b1;
      emit_ovf    = !last_r;
    end else if (idx_r == CntW'(1)) begin
      emit_val    = res_r;
      emit_filled = 1'b0;
      emit_ovf    = 1'b0;
    end else begin
      emit_val    = seen_r ? blend_full[DataW-1:0] : res_r;
      emit_filled = 1'b1;
      emit_ovf    = 1'b0;
    end
  end

  // control state and log state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= '0;
      seen_r      <= 1'b0;
      gap_r       <= '0;
      idx_r       <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.accept) begin
        idx_r <= den_in;
        if (sts.absorb) begin
          gap_r <= gap_r + GapW'(1);
        end
      end
      if (cmd.setup) begin
        step_r <= '0;
      end else if (cmd.div_step) begin
        step_r <= step_r + StepW'(1);
      end
      if (cmd.emit) begin
        idx_r <= idx_r - CntW'(1);
        if (sts.last_emit) begin
          gap_r <= '0;
          if (last_r) begin
            prev_r <= '0;
            seen_r <= 1'b0;
          end else if (!miss_r) begin
            prev_r <= res_r;
            seen_r <= 1'b1;
          end
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res_r  <= res_in;
      miss_r <= in_is_missing;
      last_r <= in_last_sample;
      den_r  <= den_in;
    end
    if (cmd.setup) begin
      dvd_r <= mag_set[DataW-1:0];
      neg_r <= d_set[DataW];
      rem_r <= '0;
    end
    if (cmd.div_step) begin
      dvd_r <= {dvd_r[DataW-2:0], rem_ge};
      rem_r <= rem_ge ? rem_sub[CntW-1:0] : rem_sh[CntW-1:0];
    end
    if (cmd.fix) begin
      qd_r <= qd_fix;
      rd_r <= rd_fix;
    end
    if (cmd.init) begin
      acc_q_r <= {prev_r[DataW-1], prev_r} + qd_r;
      acc_r_r <= rd_r;
    end else if (cmd.emit) begin
      acc_q_r <= acc_q_r + qd_r + {{DataW{1'b0}}, carry};
      acc_r_r <= carry ? sum_sub[CntW-1:0] : sum_rem[CntW-1:0];
    end
    if (cmd.emit) begin
      out_residual_r <= emit_val;
      out_filled_r   <= emit_filled;
      out_ovf_r      <= emit_ovf;
      out_end_r      <= sts.last_emit;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_residual     = out_residual_r;
  assign out_was_filled   = out_filled_r;
  assign out_gap_overflow = out_ovf_r;
  assign out_run_end      = out_end_r;

  `RGI_ASSERT_IMP(a_emit_has_items, clk, rst_n, cmd.emit, idx_r != '0)
  `RGI_ASSERT_IMP(a_measured_ends_run, clk, rst_n, out_valid_r && !out_filled_r,
                  out_end_r && !out_ovf_r)
  `RGI_ASSERT_NXT(a_absorb_counts, clk, rst_n, cmd.accept && sts.absorb,
                  gap_r == $past(gap_r) + GapW'(1))
  `RGI_ASSERT_IMP(a_blend_rem_bound, clk, rst_n,
                  cmd.emit && !miss_r && seen_r && (idx_r != CntW'(1)),
                  acc_r_r < den_r)

endmodule

[hw/rtl/residual_gap_interpolator.sv]
// Top level of the residual gap interpolator: controller plus datapath.
// Depends on rgi_pkg, rgi_ctrl and rgi_dpath.

// Takes one log sample per transfer and returns the residual (log minus
// background, Q16.16, saturated), holding missing samples back until the next
// measured sample and then filling them oldest first by linear blend; a
// leading gap takes the new residual, a missing final sample flushes the held
// gap as the last measured residual, and a gap longer than 63 is flushed with
// gap_overflow set. A measured sample closing a gap after an earlier measured
// one passes through the bit-serial divider (one quotient bit per cycle over
// 32 bits) before its results leave the output register one per cycle while
// the output is not stalled; other samples skip the divider. The next sample
// is taken while the last result of the previous one still waits in the
// output register.
module residual_gap_interpolator (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [rgi_pkg::DataW-1:0] in_log_value,
  input  logic signed [rgi_pkg::DataW-1:0] in_background_value,
  input  logic                             in_is_missing,
  input  logic                             in_last_sample,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [rgi_pkg::DataW-1:0] out_residual,
  output logic                             out_was_filled,
  output logic                             out_gap_overflow,
  output logic                             out_run_end
);
  import rgi_pkg::*;

  rgi_cmd_t cmd;
  rgi_sts_t sts;

  rgi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  rgi_dpath u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_log_value        (in_log_value),
    .in_background_value (in_background_value),
    .in_is_missing       (in_is_missing),
    .in_last_sample      (in_last_sample),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_residual        (out_residual),
    .out_was_filled      (out_was_filled),
    .out_gap_overflow    (out_gap_overflow),
    .out_run_end         (out_run_end)
  );

endmodule

[sim/residual_gap_interpolator_tb.sv]
// Self-checking testbench for residual_gap_interpolator: directed table plus random logs.
// Depends on rgi_pkg and the residual_gap_interpolator RTL; needs no files at run time.
`timescale 1ns / 100ps

module residual_gap_interpolator_tb;

  localparam int unsigned DW = rgi_pkg::DataW;
  localparam logic signed [DW-1:0] S_MAX = 32'sh7fff_ffff;
  localparam logic signed [DW-1:0] S_MIN = 32'sh8000_0000;
  localparam logic signed [DW-1:0] ONE   = 32'sh0001_0000;
  localparam int unsigned RAND_ITEMS = 330;

  typedef struct {
    logic signed [DW-1:0] residual;
    logic                 filled;
    logic                 ovf;
    logic                 run_end;
  } fill_res_t;

  // One table row: a sample repeated reps times; fixed_res marks a row whose
  // single result is written out here instead of being predicted.
  typedef struct packed {
    logic signed [DW-1:0] lv;
    logic signed [DW-1:0] bg;
    logic                 miss;
    logic                 last;
    logic [7:0]           reps;
    logic                 fixed_res;
    logic signed [DW-1:0] x_res;
    logic                 x_filled;
  } sample_row_t;

  localparam int N_ROWS = 25;
  localparam sample_row_t SAMPLE_TABLE [N_ROWS] = '{
    '{32'sd0, 32'sd0, 1'b1, 1'b0, 8'd64, 1'b0, 32'sd0, 1'b0}, // leading gap overflow
    '{32'sd0, 32'sd0, 1'b1, 1'b0, 8'd2,  1'b0, 32'sd0, 1'b0},
    '{ONE * 5, ONE,   1'b0, 1'b0, 8'd1,  1'b0, 32'sd0, 1'b0}, // leading gap takes new
    '{32'sd0, 32'sd0, 1'b0, 1'b0, 8'd1,  1'b1, 32'sd0, 1'b0},
    '{S_MAX,  S_MIN,  1'b0, 1'b0, 8'd1,  1'b1, S_MAX,  1'b0}, // saturate high
    '{S_MIN,  S_MAX,  1'b0, 1'b0, 8'd1,  1'b1, S_MIN,  1'b0}, // saturate low
    '{S_MAX,  32'sd0, 1'b0, 1'b0, 8'd1,  1'b1, S_MAX,  1'b0},
    '{32'sd0, 32'sd0, 1'b0, 1'b0, 8'd1,  1'b1, 32'sd0, 1'b0},
    '{32'sd0, 32'sd0, 1'b1, 1'b0, 8'd1,  1'b0, 32'sd0, 1'b0},
    '{32'sd1, 32'sd0, 1'b0, 1'b0, 8'd1,  1'b0, 32'sd0, 1'b0}, // half rounds up
    '{32'sd0, 32'sd0, 1'b0, 1'b0, 8'd1,  1'b1, 32'sd0, 1'b0},
    '{32'sd0, 32'sd0, 1'b1, 1'b0, 8'd1,  1'b0, 32'sd0, 1'b0},
    '{-32'sd1, 32'sd0, 1'b0, 1'b0, 8'd1, 1'b0, 32'sd0, 1'b0}, // half rounds down
    '{S_MIN,  32'sd0, 1'b0, 1'b0, 8'd1,  1'b1, S_MIN,  1'b0},
    '{32'sd0, 32'sd0, 1'b1, 1'b0, 8'd3,  1'b0, 32'sd0, 1'b0},
    '{S_MAX,  32'sd1, 1'b0, 1'b0, 8'd1,  1'b0, 32'sd0, 1'b0},
    '{S_MIN,  S_MAX,  1'b1, 1'b0, 8'd63, 1'b0, 32'sd0, 1'b0},
    '{S_MAX,  S_MIN,  1'b1, 1'b0, 8'd1,  1'b0, 32'sd0, 1'b0}, // mid-log overflow
    '{32'sd0, 32'sd0, 1'b1, 1'b0, 8'd2,  1'b0, 32'sd0, 1'b0},
    '{ONE * 3, -ONE * 2, 1'b0, 1'b0, 8'd1, 1'b0, 32'sd0, 1'b0}, // blend after flush
    '{32'sd0, 32'sd0, 1'b1, 1'b0, 8'd2,  1'b0, 32'sd0, 1'b0},
    '{32'sd0, 32'sd0, 1'b1, 1'b1, 8'd1,  1'b0, 32'sd0, 1'b0}, // trailing gap
    '{-32'sd1, -32'sd1, 1'b1, 1'b1, 8'd1, 1'b1, 32'sd0, 1'b1}, // all-missing log
    '{-ONE * 7, 32'sd0, 1'b0, 1'b1, 8'd1, 1'b1, -ONE * 7, 1'b0},
    '{ONE,    32'sd0, 1'b0, 1'b0, 8'd1,  1'b1, ONE,    1'b0}
  };

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic signed [DW-1:0] in_log_value = '0;
  logic signed [DW-1:0] in_background_value = '0;
  logic                 in_is_missing = 1'b0;
  logic                 in_last_sample = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [DW-1:0] out_residual;
  logic                 out_was_filled;
  logic                 out_gap_overflow;
  logic                 out_run_end;

  // Predictor state
  logic signed [DW-1:0]      prev_res = '0;
  logic                      seen_meas = 1'b0;
  logic [rgi_pkg::GapW-1:0]  gap_cnt = '0;

  fill_res_t residual_q[$];
  fill_res_t head;
  int        mismatch_cnt = 0;
  int        n_sent = 0;
  logic      steady = 1'b0;

  residual_gap_interpolator u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_log_value        (in_log_value),
    .in_background_value (in_background_value),
    .in_is_missing       (in_is_missing),
    .in_last_sample      (in_last_sample),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_residual        (out_residual),
    .out_was_filled      (out_was_filled),
    .out_gap_overflow    (out_gap_overflow),
    .out_run_end         (out_run_end)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Work out the results one accepted sample causes and queue them.
  function automatic void absorb_sample(input logic signed [DW-1:0] lv,
                                        input logic signed [DW-1:0] bg,
                                        input logic miss, input logic last);
    longint               diff;
    longint               num;
    longint               den;
    longint               quo;
    logic signed [DW-1:0] r;
    int                   m;
    int                   total;
    fill_res_t            item;
    if (miss) begin
      if (last || gap_cnt >= rgi_pkg::MAX_GAP) begin
        // flush the held gap and this sample as the last measured residual
        total = int'(gap_cnt) + 1;
        for (int k = 0; k < total; k++) begin
          item.residual = prev_res;
          item.filled   = 1'b1;
          item.ovf      = !last;
          item.run_end  = (k == total - 1);
          residual_q.push_back(item);
        end
        gap_cnt = '0;
        if (last) begin
          prev_res  = '0;
          seen_meas = 1'b0;
        end
      end else begin
        gap_cnt = gap_cnt + 1'b1;
      end
    end else begin
      diff = longint'(lv) - longint'(bg);
      if (diff > longint'(S_MAX)) r = S_MAX;
      else if (diff < longint'(S_MIN)) r = S_MIN;
      else r = diff[DW-1:0];
      m   = int'(gap_cnt);
      den = m + 1;
      for (int k = 1; k <= m; k++) begin
        item.residual = r;
        if (seen_meas) begin
          // round to nearest, ties away from zero
          num = longint'(prev_res) * (m + 1 - k) + longint'(r) * k;
          if (num >= 0) quo = (num + den / 2) / den;
          else quo = -((-num + den / 2) / den);
          item.residual = quo[DW-1:0];
        end
        item.filled  = 1'b1;
        item.ovf     = 1'b0;
        item.run_end = 1'b0;
        residual_q.push_back(item);
      end
      item.residual = r;
      item.filled   = 1'b0;
      item.ovf      = 1'b0;
      item.run_end  = 1'b1;
      residual_q.push_back(item);
      prev_res  = last ? '0 : r;
      seen_meas = !last;
      gap_cnt   = '0;
    end
  endfunction

  function automatic logic signed [DW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return S_MAX;
      1:       return S_MIN;
      2:       return $urandom_range(0, 1) ? -32'sd1 : 32'sd0;
      3, 4, 5: return $urandom();
      default: return $signed($urandom_range(0, 2 ** 21)) - 32'sd1048576;
    endcase
  endfunction

  task automatic send_sample(input logic signed [DW-1:0] lv,
                             input logic signed [DW-1:0] bg,
                             input logic miss, input logic last);
    while (!steady && $urandom_range(0, 99) < 37) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_log_value        <= lv;
    in_background_value <= bg;
    in_is_missing       <= miss;
    in_last_sample      <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    absorb_sample(lv, bg, miss, last);
    n_sent++;
  endtask

  task automatic check_field(input string what, input longint want, input longint got);
    if (want != got) begin
      mismatch_cnt++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(0, 99) < 37);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (residual_q.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: unexpected transfer, expected none, actual residual %0d",
                 $time, out_residual);
      end else begin
        head = residual_q.pop_front();
        check_field("residual", longint'(head.residual), longint'(out_residual));
        check_field("was_filled", longint'(head.filled), longint'(out_was_filled));
        check_field("gap_overflow", longint'(head.ovf), longint'(out_gap_overflow));
        check_field("run_end", longint'(head.run_end), longint'(out_run_end));
      end
    end
  end

  initial begin
    sample_row_t          row;
    fill_res_t            given;
    int                   base;
    int                   len;
    int                   gap;
    int                   pick;
    logic                 noisy;
    logic                 final_seg;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_ROWS; i++) begin
      row = SAMPLE_TABLE[i];
      for (int j = 0; j < int'(row.reps); j++) begin
        send_sample(row.lv, row.bg, row.miss, row.last);
      end
      if (row.fixed_res) begin
        // replace the predicted single result with the one written in the row
        void'(residual_q.pop_back());
        given.residual = row.x_res;
        given.filled   = row.x_filled;
        given.ovf      = 1'b0;
        given.run_end  = 1'b1;
        residual_q.push_back(given);
      end
    end

    // Random logs: mostly well-formed gap/measure runs, some pure noise
    base = n_sent;
    while (n_sent - base < RAND_ITEMS) begin
      noisy = ($urandom_range(0, 9) == 0);
      len   = $urandom_range(1, 25);
      for (int s = 0; s < len; s++) begin
        steady    = (n_sent - base >= 180) && (n_sent - base < 300);
        final_seg = (s == len - 1);
        if (noisy) begin
          send_sample(pick_value(), pick_value(), 1'($urandom_range(0, 1)), final_seg);
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 60) gap = 0;
          else if (pick < 85) gap = $urandom_range(1, 4);
          else if (pick < 96) gap = $urandom_range(5, 20);
          else gap = $urandom_range(58, 70);
          for (int g = 0; g < gap; g++) begin
            send_sample($urandom(), $urandom(), 1'b1, 1'b0);
          end
          send_sample(pick_value(), pick_value(),
                      final_seg && ($urandom_range(0, 3) == 0), final_seg);
        end
      end
    end
    steady = 1'b0;

    in_valid <= 1'b0;
    while (residual_q.size() != 0) @(posedge clk);
    // drain: catch any extra transfer
    repeat (120) @(posedge clk);
    if (mismatch_cnt == 0 && residual_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[residual_gap_interpolator.f]
+incdir+hw/rtl
hw/rtl/rgi_pkg.sv
hw/rtl/rgi_ctrl.sv
hw/rtl/rgi_dpath.sv
hw/rtl/residual_gap_interpolator.sv
sim/residual_gap_interpolator_tb.sv
